// File: src/p2lri_pkg.sv
// ----------------------------------------------------------------------------
// Point to ray index package
// Widths, codes, tables and pipeline stage types shared by the cells and the
// top level.
// ----------------------------------------------------------------------------
package p2lri_pkg;

  localparam int CW            = 24;
  localparam int MAG_W         = CW;
  localparam int SQ_W          = 2 * CW;
  localparam int SQRT_STAGES   = CW;
  localparam int AB            = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN      = 24;
  localparam int NORM_TOP      = 40;
  localparam int XY_W          = NORM_TOP + 4;
  localparam int ACC_W         = 33;
  localparam int SH_W          = 6;
  localparam int TURN_W        = 33;
  localparam int CLAMP_W       = 31;
  localparam int NUM_W         = 18;
  localparam int DEN_W         = 17;
  localparam int QB            = 16;
  localparam int QK_W          = 4;
  localparam int DIVC_W        = DEN_W + QB - 1;
  localparam int REG_IDX_W     = 2;

  localparam logic [TURN_W-1:0] T_QUARTER = TURN_W'(64'd1 << 30);
  localparam logic [TURN_W-1:0] T_HALF    = TURN_W'(64'd1 << 31);
  localparam logic [TURN_W-1:0] T_FULL    = TURN_W'(64'd1 << 32);
  localparam logic [TURN_W-1:0] HALF_LSB  = TURN_W'(64'd1 << (31 - AB));

  localparam logic [1:0] ST_INSIDE  = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_ZERO    = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_AZIM_STEP   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INCL_STEP   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_INCL_BOTTOM = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_INCL_LIMIT  = 2'd3;

  localparam logic [15:0] RST_AZIM_STEP   = 16'd364;
  localparam logic [15:0] RST_INCL_STEP   = 16'd364;
  localparam logic [15:0] RST_INCL_BOTTOM = 16'hF555;
  localparam logic [14:0] RST_INCL_LIMIT  = 15'd2731;

  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81};

  typedef struct packed {
    logic             valid;
    logic             xn;
    logic             yn;
    logic             zn;
    logic             zero;
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    logic [MAG_W-1:0] az;
    logic [SQ_W-1:0]  rem;
    logic [SQ_W-1:0]  root;
  } sq_t;

  typedef struct packed {
    logic                    valid;
    logic                    xn;
    logic                    yn;
    logic                    zn;
    logic                    zero;
    logic                    azero;
    logic signed [XY_W-1:0]  xa;
    logic signed [XY_W-1:0]  ya;
    logic signed [ACC_W-1:0] acca;
    logic signed [XY_W-1:0]  xi;
    logic signed [XY_W-1:0]  yi;
    logic signed [ACC_W-1:0] acci;
  } cd_t;

  typedef struct packed {
    logic             valid;
    logic [1:0]       status;
    logic [AB-1:0]    azim;
    logic [AB-1:0]    incl;
    logic [NUM_W-1:0] rema;
    logic [NUM_W-1:0] remi;
    logic [QB-1:0]    qa;
    logic [QB-1:0]    qi;
  } dv_t;

  function automatic logic [SH_W-1:0] msb_pos(input logic [MAG_W-1:0] v);
    logic [SH_W-1:0] p;
    p = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (v[i]) begin
        p = SH_W'(i);
      end
    end
    return p;
  endfunction

endpackage

// File: src/point_to_lidar_ray_index.sv
// ----------------------------------------------------------------------------
// Point to lidar ray index
// Projects a 3D point onto the azimuth and inclination ray grid of a scanner.
// ----------------------------------------------------------------------------
// The block takes one point per clock while the pipeline is not held, and
// returns results in order. The pipeline is a chain of cells: 24 square root cells,
// 16 CORDIC cells that solve azimuth and inclination side by side, and 16
// divider cells for the two indices, plus eight single stages for input,
// squaring, summing, two normalizing stages, angle clamping, angle rounding
// and the output register. The whole pipeline holds while a result waits on
// out_ready. Configuration writes are taken at any time and must only be
// issued while no transaction is in flight.
module point_to_lidar_ray_index (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [p2lri_pkg::CW-1:0]      in_pos_x,
  input  logic signed [p2lri_pkg::CW-1:0]      in_pos_y,
  input  logic signed [p2lri_pkg::CW-1:0]      in_pos_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [p2lri_pkg::AB-1:0]             out_azim_angle,
  output logic signed [p2lri_pkg::AB-1:0]      out_incl_angle,
  output logic [15:0]                          out_azim_index,
  output logic [15:0]                          out_incl_index,
  output logic [1:0]                           out_status,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [p2lri_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [15:0]                          cfg_data
);
  import p2lri_pkg::*;

  logic        en;
  logic [15:0] azim_step_r, incl_step_r, incl_bottom_r;
  logic [14:0] incl_limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      azim_step_r   <= RST_AZIM_STEP;
      incl_step_r   <= RST_INCL_STEP;
      incl_bottom_r <= RST_INCL_BOTTOM;
      incl_limit_r  <= RST_INCL_LIMIT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_AZIM_STEP:   azim_step_r   <= cfg_data;
        REG_INCL_STEP:   incl_step_r   <= cfg_data;
        REG_INCL_BOTTOM: incl_bottom_r <= cfg_data;
        REG_INCL_LIMIT:  incl_limit_r  <= cfg_data[14:0];
      endcase
    end
  end

  logic             out_valid_r;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Input stage: magnitudes and signs.
  logic             s0_valid_r, s0_xn_r, s0_yn_r, s0_zn_r;
  logic [MAG_W-1:0] s0_ax_r, s0_ay_r, s0_az_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_valid;
      s0_xn_r    <= in_pos_x[CW-1];
      s0_yn_r    <= in_pos_y[CW-1];
      s0_zn_r    <= in_pos_z[CW-1];
      s0_ax_r    <= in_pos_x[CW-1] ? MAG_W'(0) - MAG_W'(in_pos_x) : MAG_W'(in_pos_x);
      s0_ay_r    <= in_pos_y[CW-1] ? MAG_W'(0) - MAG_W'(in_pos_y) : MAG_W'(in_pos_y);
      s0_az_r    <= in_pos_z[CW-1] ? MAG_W'(0) - MAG_W'(in_pos_z) : MAG_W'(in_pos_z);
    end
  end

  // Squaring stage.
  logic             s1_valid_r, s1_xn_r, s1_yn_r, s1_zn_r;
  logic [MAG_W-1:0] s1_ax_r, s1_ay_r, s1_az_r;
  logic [SQ_W-1:0]  s1_xsq_r, s1_ysq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= s0_valid_r;
      s1_xn_r    <= s0_xn_r;
      s1_yn_r    <= s0_yn_r;
      s1_zn_r    <= s0_zn_r;
      s1_ax_r    <= s0_ax_r;
      s1_ay_r    <= s0_ay_r;
      s1_az_r    <= s0_az_r;
      s1_xsq_r   <= SQ_W'(s0_ax_r) * SQ_W'(s0_ax_r);
      s1_ysq_r   <= SQ_W'(s0_ay_r) * SQ_W'(s0_ay_r);
    end
  end

  // Sum stage feeds the square root chain.
  sq_t sq_c [SQRT_STAGES+1];
  sq_t sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r.valid <= 1'b0;
    end else if (en) begin
      sq_r.valid <= s1_valid_r;
      sq_r.xn    <= s1_xn_r;
      sq_r.yn    <= s1_yn_r;
      sq_r.zn    <= s1_zn_r;
      sq_r.zero  <= (s1_ax_r == '0) && (s1_ay_r == '0) && (s1_az_r == '0);
      sq_r.ax    <= s1_ax_r;
      sq_r.ay    <= s1_ay_r;
      sq_r.az    <= s1_az_r;
      sq_r.rem   <= s1_xsq_r + s1_ysq_r;
      sq_r.root  <= '0;
    end
  end

  assign sq_c[0] = sq_r;

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
    p2lri_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .k     (5'(SQRT_STAGES - 1 - g)),
      .s_in  (sq_c[g]),
      .s_out (sq_c[g+1])
    );
  end

  // Normalize stage one: shift amounts.
  sq_t              sl;
  logic [MAG_W-1:0] rxy, m_a, m_i;
  logic             n1_valid_r, n1_xn_r, n1_yn_r, n1_zn_r, n1_zero_r, n1_azero_r;
  logic [MAG_W-1:0] n1_ax_r, n1_ay_r, n1_rxy_r, n1_az_r;
  logic [SH_W-1:0]  n1_sha_r, n1_shi_r;

  always_comb begin
    sl  = sq_c[SQRT_STAGES];
    rxy = sl.root[MAG_W-1:0];
    m_a = (sl.ax > sl.ay) ? sl.ax : sl.ay;
    m_i = (rxy > sl.az) ? rxy : sl.az;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n1_valid_r <= 1'b0;
    end else if (en) begin
      n1_valid_r <= sl.valid;
      n1_xn_r    <= sl.xn;
      n1_yn_r    <= sl.yn;
      n1_zn_r    <= sl.zn;
      n1_zero_r  <= sl.zero;
      n1_azero_r <= (sl.ax == '0) && (sl.ay == '0);
      n1_ax_r    <= sl.ax;
      n1_ay_r    <= sl.ay;
      n1_rxy_r   <= rxy;
      n1_az_r    <= sl.az;
      n1_sha_r   <= SH_W'(NORM_TOP) - msb_pos(m_a);
      n1_shi_r   <= SH_W'(NORM_TOP) - msb_pos(m_i);
    end
  end

  // Normalize stage two feeds the CORDIC chain.
  cd_t cd_c [CORDIC_STAGES+1];
  cd_t cd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_r.valid <= 1'b0;
    end else if (en) begin
      cd_r.valid <= n1_valid_r;
      cd_r.xn    <= n1_xn_r;
      cd_r.yn    <= n1_yn_r;
      cd_r.zn    <= n1_zn_r;
      cd_r.zero  <= n1_zero_r;
      cd_r.azero <= n1_azero_r;
      cd_r.xa    <= signed'(XY_W'(n1_ax_r) << n1_sha_r);
      cd_r.ya    <= signed'(XY_W'(n1_ay_r) << n1_sha_r);
      cd_r.xi    <= signed'(XY_W'(n1_rxy_r) << n1_shi_r);
      cd_r.yi    <= signed'(XY_W'(n1_az_r) << n1_shi_r);
      cd_r.acca  <= '0;
      cd_r.acci  <= '0;
    end
  end

  assign cd_c[0] = cd_r;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    p2lri_cordic_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .idx   (5'(g)),
      .c_in  (cd_c[g]),
      .c_out (cd_c[g+1])
    );
  end

  // Angle stage one: clamp and unfold the quadrant.
  function automatic logic [CLAMP_W-1:0] clamp_q(input logic signed [ACC_W-1:0] acc);
    if (acc < 0) begin
      return '0;
    end else if (acc > signed'(T_QUARTER)) begin
      return CLAMP_W'(T_QUARTER);
    end
    return acc[CLAMP_W-1:0];
  endfunction

  cd_t                cl;
  logic [TURN_W-1:0]  a_ext, t_nxt;
  logic [CLAMP_W-1:0] icl_nxt;
  logic               p1_valid_r, p1_zn_r, p1_zero_r;
  logic [TURN_W-1:0]  p1_t_r;
  logic [CLAMP_W-1:0] p1_icl_r;

  always_comb begin
    cl      = cd_c[CORDIC_STAGES];
    a_ext   = cl.azero ? '0 : TURN_W'(clamp_q(cl.acca));
    icl_nxt = cl.azero ? CLAMP_W'(T_QUARTER) : clamp_q(cl.acci);
    unique case ({cl.xn, cl.yn})
      2'b00:   t_nxt = a_ext;
      2'b10:   t_nxt = T_HALF - a_ext;
      2'b11:   t_nxt = T_HALF + a_ext;
      default: t_nxt = T_FULL - a_ext;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (en) begin
      p1_valid_r <= cl.valid;
      p1_zn_r    <= cl.zn;
      p1_zero_r  <= cl.zero;
      p1_t_r     <= t_nxt;
      p1_icl_r   <= icl_nxt;
    end
  end

  // Angle stage two: rounding, status and division operands.
  logic [TURN_W:0]           tsum;
  logic [TURN_W-1:0]         isum;
  logic [AB-1:0]             azim_nxt;
  logic [AB-2:0]             imag;
  logic signed [AB-1:0]      incl_nxt;
  logic signed [NUM_W-1:0]   dlt;
  logic [15:0]               sa_eff, si_eff;
  logic [DEN_W-1:0]          den_a, den_i;
  dv_t                       dv_c [QB+1];
  dv_t                       dv_r;
  dv_t                       dv_nxt;

  always_comb begin
    sa_eff   = (azim_step_r == '0) ? 16'd1 : azim_step_r;
    si_eff   = (incl_step_r == '0) ? 16'd1 : incl_step_r;
    den_a    = {sa_eff, 1'b0};
    den_i    = {si_eff, 1'b0};
    tsum     = (TURN_W+1)'(p1_t_r) + (TURN_W+1)'(HALF_LSB);
    isum     = TURN_W'(p1_icl_r) + HALF_LSB;
    azim_nxt = tsum[31:32-AB];
    imag     = isum[30:32-AB];
    incl_nxt = p1_zn_r ? -signed'(AB'(imag)) : signed'(AB'(imag));
    dlt      = NUM_W'(incl_nxt) - NUM_W'(signed'(incl_bottom_r));
    dv_nxt.valid = p1_valid_r;
    dv_nxt.azim  = azim_nxt;
    dv_nxt.incl  = incl_nxt;
    dv_nxt.rema  = {1'b0, azim_nxt, 1'b0} + NUM_W'(sa_eff);
    dv_nxt.remi  = (dlt <= 0) ? '0 : ((dlt <<< 1) + NUM_W'(si_eff));
    dv_nxt.qa    = '0;
    dv_nxt.qi    = '0;
    if (p1_zero_r) begin
      dv_nxt.status = ST_ZERO;
    end else if (AB'(imag) > AB'(incl_limit_r)) begin
      dv_nxt.status = ST_OUTSIDE;
    end else begin
      dv_nxt.status = ST_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r.valid <= 1'b0;
    end else if (en) begin
      dv_r <= dv_nxt;
    end
  end

  assign dv_c[0] = dv_r;

  for (genvar g = 0; g < QB; g++) begin : g_div
    p2lri_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .k     (QK_W'(QB - 1 - g)),
      .den_a (den_a),
      .den_i (den_i),
      .d_in  (dv_c[g]),
      .d_out (dv_c[g+1])
    );
  end

  // Output register.
  dv_t                  dl;
  logic                 zr;
  logic [AB-1:0]        out_azim_angle_r;
  logic signed [AB-1:0] out_incl_angle_r;
  logic [15:0]          out_azim_index_r, out_incl_index_r;
  logic [1:0]           out_status_r;

  assign dl = dv_c[QB];
  assign zr = (dl.status == ST_ZERO);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r      <= dl.valid;
      out_azim_angle_r <= zr ? '0 : dl.azim;
      out_incl_angle_r <= zr ? '0 : dl.incl;
      out_azim_index_r <= zr ? '0 : dl.qa;
      out_incl_index_r <= zr ? '0 : dl.qi;
      out_status_r     <= dl.status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_azim_angle = out_azim_angle_r;
  assign out_incl_angle = out_incl_angle_r;
  assign out_azim_index = out_azim_index_r;
  assign out_incl_index = out_incl_index_r;
  assign out_status     = out_status_r;

  logic [AB-1:0] incl_abs;
  assign incl_abs = out_incl_angle_r[AB-1] ? AB'(-out_incl_angle_r) : AB'(out_incl_angle_r);

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_ZERO |->
      out_azim_angle_r == '0 && out_incl_angle_r == '0 &&
      out_azim_index_r == '0 && out_incl_index_r == '0)
    else $error("zero vector result carries nonzero fields");

  a_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_OUTSIDE |-> incl_abs > AB'(incl_limit_r))
    else $error("outside status with inclination inside the limit");

  a_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_INSIDE |-> incl_abs <= AB'(incl_limit_r))
    else $error("inside status with inclination beyond the limit");

  a_incl_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> incl_abs <= AB'(T_QUARTER >> (32 - AB)))
    else $error("inclination beyond a quarter turn");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(dl))
    else $error("divider chain moved while stalled");

endmodule

// File: src/p2lri_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// One restoring step of the integer square root, carrying the point along.
// ----------------------------------------------------------------------------
module p2lri_sqrt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [4:0]        k,
  input  p2lri_pkg::sq_t    s_in,
  output p2lri_pkg::sq_t    s_out
);
  import p2lri_pkg::*;

  logic [SQ_W-1:0] bit_v;
  logic [SQ_W-1:0] trial;
  sq_t             s_nxt;
  sq_t             s_r;

  always_comb begin
    bit_v = SQ_W'(1) << {k, 1'b0};
    trial = s_in.root + bit_v;
    s_nxt = s_in;
    if (s_in.rem >= trial) begin
      s_nxt.rem  = s_in.rem - trial;
      s_nxt.root = (s_in.root >> 1) + bit_v;
    end else begin
      s_nxt.root = s_in.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.valid <= 1'b0;
    end else if (en) begin
      s_r <= s_nxt;
    end
  end

  assign s_out = s_r;

endmodule

// File: src/p2lri_cordic_cell.sv
// ----------------------------------------------------------------------------
// CORDIC cell
// One vectoring micro-rotation for the azimuth pair and the inclination pair.
// ----------------------------------------------------------------------------
module p2lri_cordic_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [4:0]        idx,
  input  p2lri_pkg::cd_t    c_in,
  output p2lri_pkg::cd_t    c_out
);
  import p2lri_pkg::*;

  logic signed [ACC_W-1:0] at;
  logic signed [XY_W-1:0]  xsa, ysa, xsi, ysi;
  cd_t                     c_nxt;
  cd_t                     c_r;

  always_comb begin
    at    = signed'({1'b0, ATAN_TAB[idx]});
    xsa   = c_in.xa >>> idx;
    ysa   = c_in.ya >>> idx;
    xsi   = c_in.xi >>> idx;
    ysi   = c_in.yi >>> idx;
    c_nxt = c_in;
    if (c_in.ya >= 0) begin
      c_nxt.xa   = c_in.xa + ysa;
      c_nxt.ya   = c_in.ya - xsa;
      c_nxt.acca = c_in.acca + at;
    end else begin
      c_nxt.xa   = c_in.xa - ysa;
      c_nxt.ya   = c_in.ya + xsa;
      c_nxt.acca = c_in.acca - at;
    end
    if (c_in.yi >= 0) begin
      c_nxt.xi   = c_in.xi + ysi;
      c_nxt.yi   = c_in.yi - xsi;
      c_nxt.acci = c_in.acci + at;
    end else begin
      c_nxt.xi   = c_in.xi - ysi;
      c_nxt.yi   = c_in.yi + xsi;
      c_nxt.acci = c_in.acci - at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.valid <= 1'b0;
    end else if (en) begin
      c_r <= c_nxt;
    end
  end

  assign c_out = c_r;

endmodule

// File: src/p2lri_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring quotient bit for the azimuth and inclination index divisions.
// ----------------------------------------------------------------------------
module p2lri_div_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic [p2lri_pkg::QK_W-1:0]  k,
  input  logic [p2lri_pkg::DEN_W-1:0] den_a,
  input  logic [p2lri_pkg::DEN_W-1:0] den_i,
  input  p2lri_pkg::dv_t              d_in,
  output p2lri_pkg::dv_t              d_out
);
  import p2lri_pkg::*;

  logic [DIVC_W-1:0] sa, si;
  dv_t               d_nxt;
  dv_t               d_r;

  always_comb begin
    sa    = DIVC_W'(den_a) << k;
    si    = DIVC_W'(den_i) << k;
    d_nxt = d_in;
    if (DIVC_W'(d_in.rema) >= sa) begin
      d_nxt.rema  = d_in.rema - sa[NUM_W-1:0];
      d_nxt.qa[k] = 1'b1;
    end
    if (DIVC_W'(d_in.remi) >= si) begin
      d_nxt.remi  = d_in.remi - si[NUM_W-1:0];
      d_nxt.qi[k] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule
